>>> hdl/rau_pkg.sv
`timescale 1ns / 1ps
// rau_pkg: shared widths, mode codes and state types for the rational arithmetic unit.
// No dependencies; used by every module of the block.

package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int MODE_W            = 3;
  localparam int RES_NUM_W         = 32;
  localparam int RES_DEN_W         = 31;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4
  } mode_t;

  // Top-level sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_PREP,
    S_RED,
    S_HOLD
  } top_state_t;

  // Reduction unit: gcd then two divisions
  typedef enum logic [1:0] {
    R_IDLE,
    R_GCD,
    R_DIVA,
    R_DIVD
  } red_state_t;

endpackage

>>> hdl/rau_reduce.sv
`timescale 1ns / 1ps
// rau_reduce: reduces mag/den to lowest terms with one shared subtractor.
// Binary gcd, then two restoring divisions by the odd gcd part; uses rau_pkg.

module rau_reduce #(
  parameter int N = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] mag,
  input  logic [N-1:0] den,
  output logic         done,
  output logic [N-1:0] q_mag,
  output logic [N-1:0] q_den
);
  import rau_pkg::*;

  localparam int CW = $clog2(N);

  red_state_t    state, state_next;
  logic [N-1:0]  u, v, qa, qd, g, r, x;
  logic [CW-1:0] cnt;
  logic [N:0]    op_a, op_b, diff;
  logic          borrow, qbit, last, gcd_hit;

  // Shared subtractor: u - v during gcd, partial remainder - g during division
  always_comb begin
    if (state == R_GCD) begin
      op_a = {1'b0, u};
      op_b = {1'b0, v};
    end else begin
      op_a = {r, x[N-1]};
      op_b = {1'b0, g};
    end
  end

  assign diff    = op_a - op_b;
  assign borrow  = diff[N];
  assign qbit    = ~borrow;
  assign last    = (cnt == CW'(N - 1));
  assign gcd_hit = u[0] && v[0] && (diff == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == R_DIVD) && last;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      R_IDLE: if (start) state_next = R_GCD;
      R_GCD:  if (gcd_hit) state_next = R_DIVA;
      R_DIVA: if (last) state_next = R_DIVD;
      R_DIVD: if (last) state_next = R_IDLE;
      default: state_next = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        if (start) begin
          u  <= mag;
          v  <= den;
          qa <= mag;
          qd <= den;
        end
      end
      R_GCD: begin
        if (!u[0] && !v[0]) begin
          // common factor of two: strip it from the dividends too
          u  <= u >> 1;
          v  <= v >> 1;
          qa <= qa >> 1;
          qd <= qd >> 1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (gcd_hit) begin
          g   <= u;
          r   <= '0;
          x   <= qa;
          cnt <= '0;
        end else if (borrow) begin
          u <= v;
          v <= u;
        end else begin
          u <= diff[N-1:0];
        end
      end
      R_DIVA, R_DIVD: begin
        if (last && state == R_DIVA) begin
          // first quotient done: load the denominator for the second pass
          q_mag <= {x[N-2:0], qbit};
          r     <= '0;
          x     <= qd;
          cnt   <= '0;
        end else begin
          r   <= borrow ? op_a[N-1:0] : diff[N-1:0];
          x   <= {x[N-2:0], qbit};
          cnt <= cnt + CW'(1);
          if (last) begin
            q_den <= {x[N-2:0], qbit};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/rational_arith_unit_top.sv
`timescale 1ns / 1ps
// rational_arith_unit_top: add, subtract, multiply, divide or compare two fractions.
// Depends on rau_pkg and rau_reduce.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_stall  | mode, a_num, a_den, b_num, b_den
//   out     | out_valid/out_stall| res_num, res_den, less, equal, div_zero
//
// One request at a time. A request has its four products formed in the shared multiplier
// (one product per cycle), then combined and taken to a magnitude, then goes to the
// reduction unit: a binary gcd of the two operands, then two divisions with N-bit
// quotients, N = 2*OPERAND_WIDTH; the hold state then hands the result off. Compare,
// divide by zero, unused modes and zero results skip reduction. Reset is synchronous
// and clears the sequencer and out_valid. A finished result waits in the output
// register under out_stall while the next request is taken.

module rational_arith_unit_top #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rau_pkg::MODE_W-1:0]          mode,
  input  logic signed [OPERAND_WIDTH-1:0]     a_num,
  input  logic signed [OPERAND_WIDTH-1:0]     a_den,
  input  logic signed [OPERAND_WIDTH-1:0]     b_num,
  input  logic signed [OPERAND_WIDTH-1:0]     b_den,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rau_pkg::RES_NUM_W-1:0] res_num,
  output logic [rau_pkg::RES_DEN_W-1:0]       res_den,
  output logic                                less,
  output logic                                equal,
  output logic                                div_zero
);
  import rau_pkg::*;

  localparam int W    = OPERAND_WIDTH;
  localparam int N    = 2 * W;
  localparam int NUMW = N + 1;
  localparam int RNW  = (NUMW > RES_NUM_W) ? NUMW : RES_NUM_W;
  localparam int RDW  = (N > RES_DEN_W) ? N : RES_DEN_W;

  top_state_t state, state_next;

  // Latched request, denominators already repaired
  mode_t               mode_q;
  logic signed [W-1:0] an, ad, bn, bd;

  // Shared multiplier and its product registers
  logic [1:0]          mcnt;
  logic signed [W-1:0] mul_x, mul_y;
  logic signed [N-1:0] mul_p;
  logic signed [N-1:0] p_prod, q_prod, r_prod, s_prod;

  // Unreduced result
  logic signed [NUMW-1:0] num;
  logic [N-1:0]           den;
  logic                   neg;
  logic [N-1:0]           mag_c;

  // Reduction unit hookup
  logic                   red_start, red_done;
  logic [N-1:0]           red_mag, red_den;
  logic signed [NUMW-1:0] red_mag_s, red_num;
  logic signed [RNW-1:0]  red_num_w;
  logic [RDW-1:0]         red_den_w;

  // Finished result, waiting for the output register
  logic signed [RES_NUM_W-1:0] rnum;
  logic [RES_DEN_W-1:0]        rden;
  logic                        rless, requal, rdz;
  logic                        out_free;

  assign out_free = !out_valid || !out_stall;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    red_start  = 1'b0;
    case (state)
      S_IDLE: if (in_valid) state_next = S_MUL;
      S_MUL:  if (mcnt == 2'd3) state_next = S_COMB;
      S_COMB: begin
        case (mode_q)
          MODE_ADD, MODE_SUB, MODE_MUL: state_next = S_PREP;
          MODE_DIV: state_next = (bn == '0) ? S_HOLD : S_PREP;
          default:  state_next = S_HOLD;
        endcase
      end
      S_PREP: begin
        if (mag_c == '0) begin
          state_next = S_HOLD;
        end else begin
          red_start  = 1'b1;
          state_next = S_RED;
        end
      end
      S_RED:  if (red_done) state_next = S_HOLD;
      S_HOLD: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Multiplier operand select: P = an*bd, Q = bn*ad, R = ad*bd, S = an*bn
  always_comb begin
    case (mcnt)
      2'd0:    begin mul_x = an; mul_y = bd; end
      2'd1:    begin mul_x = bn; mul_y = ad; end
      2'd2:    begin mul_x = ad; mul_y = bd; end
      default: begin mul_x = an; mul_y = bn; end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  assign mag_c = num[NUMW-1] ? N'(-num) : N'(num);

  // Sign goes back on after reduction; keep the low result bits
  assign red_mag_s = {1'b0, red_mag};
  assign red_num   = neg ? -red_mag_s : red_mag_s;
  assign red_num_w = RNW'(red_num);
  assign red_den_w = RDW'(red_den);

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          mode_q <= mode_t'(mode);
          an     <= a_num;
          bn     <= b_num;
          ad     <= (a_den[W-1] || a_den == '0) ? W'(1) : a_den;
          bd     <= (b_den[W-1] || b_den == '0) ? W'(1) : b_den;
          mcnt   <= '0;
        end
      end
      S_MUL: begin
        case (mcnt)
          2'd0:    p_prod <= mul_p;
          2'd1:    q_prod <= mul_p;
          2'd2:    r_prod <= mul_p;
          default: s_prod <= mul_p;
        endcase
        mcnt <= mcnt + 2'd1;
      end
      S_COMB: begin
        // default result 0/1 with flags low
        rnum   <= '0;
        rden   <= RES_DEN_W'(1);
        rless  <= 1'b0;
        requal <= 1'b0;
        rdz    <= 1'b0;
        case (mode_q)
          MODE_ADD: begin
            num <= NUMW'(p_prod) + NUMW'(q_prod);
            den <= N'(r_prod);
          end
          MODE_SUB: begin
            num <= NUMW'(p_prod) - NUMW'(q_prod);
            den <= N'(r_prod);
          end
          MODE_MUL: begin
            num <= NUMW'(s_prod);
            den <= N'(r_prod);
          end
          MODE_DIV: begin
            // negative divisor: move its sign into the numerator
            rdz <= (bn == '0);
            num <= bn[W-1] ? -NUMW'(p_prod) : NUMW'(p_prod);
            den <= bn[W-1] ? N'(-q_prod) : N'(q_prod);
          end
          MODE_CMP: begin
            rless  <= (p_prod < q_prod);
            requal <= (p_prod == q_prod);
          end
          default: ;
        endcase
      end
      S_PREP: begin
        neg <= num[NUMW-1];
      end
      S_RED: begin
        if (red_done) begin
          rnum <= red_num_w[RES_NUM_W-1:0];
          rden <= red_den_w[RES_DEN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  rau_reduce #(
    .N(N)
  ) u_reduce (
    .clk   (clk),
    .rst   (rst),
    .start (red_start),
    .mag   (mag_c),
    .den   (den),
    .done  (red_done),
    .q_mag (red_mag),
    .q_den (red_den)
  );

  // Output register: hold under stall, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && out_free) begin
      res_num  <= rnum;
      res_den  <= rden;
      less     <= rless;
      equal    <= requal;
      div_zero <= rdz;
    end
  end

endmodule

>>> hdl/rau_chk.sv
`timescale 1ns / 1ps
// rau_chk: port-level checks for rational_arith_unit_top, bound to the top level.
// Depends on rau_pkg for port widths.

module rau_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [rau_pkg::RES_NUM_W-1:0] res_num,
  input logic [rau_pkg::RES_DEN_W-1:0]        res_den,
  input logic                                 less,
  input logic                                 equal,
  input logic                                 div_zero
);

  // The input side closes right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input side open right after a request was taken");

  // A new result appears only while the sequencer is busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no request in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den))
    else $error("stalled result dropped or changed");

  a_div_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_num == 0 && res_den == 1 && !less && !equal)
    else $error("divide by zero did not give 0/1 with compare flags low");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(less && equal))
    else $error("less and equal both set");

endmodule

bind rational_arith_unit_top rau_chk u_rau_chk (.*);
